// ===== hw/rtl/bvalu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvalu_pkg: shared types and opcodes for the bit-vector ALU
// Holds the input and result word structs and the command codes.
// ----------------------------------------------------------------------------
package bvalu_pkg;

	localparam logic [4:0] CMD_NOT     = 5'd0;
	localparam logic [4:0] CMD_NEG     = 5'd1;
	localparam logic [4:0] CMD_SEXT    = 5'd2;
	localparam logic [4:0] CMD_ZEXT    = 5'd3;
	localparam logic [4:0] CMD_SHL     = 5'd4;
	localparam logic [4:0] CMD_LSHR    = 5'd5;
	localparam logic [4:0] CMD_ASHR    = 5'd6;
	localparam logic [4:0] CMD_AND     = 5'd7;
	localparam logic [4:0] CMD_OR      = 5'd8;
	localparam logic [4:0] CMD_XOR     = 5'd9;
	localparam logic [4:0] CMD_SUB     = 5'd10;
	localparam logic [4:0] CMD_EXTRACT = 5'd11;
	localparam logic [4:0] CMD_CONCAT  = 5'd12;
	localparam logic [4:0] CMD_MUL     = 5'd13;
	localparam logic [4:0] CMD_ADD     = 5'd14;
	localparam logic [4:0] CMD_UDIV    = 5'd15;
	localparam logic [4:0] CMD_UREM    = 5'd16;
	localparam logic [4:0] CMD_SDIV    = 5'd17;
	localparam logic [4:0] CMD_SREM    = 5'd18;
	localparam logic [4:0] CMD_SMOD    = 5'd19;

	typedef struct packed {
		logic [4:0]  command;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
		logic [5:0]  operand_c;
		logic [6:0]  result_width;
		logic [6:0]  first_width;
		logic [6:0]  second_width;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result;
		logic        bad_command;
	} out_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bitvector_alu_64.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitvector_alu_64: pipelined SMT-LIB bit-vector evaluator
// One operation per word at result widths 1..DATA_WIDTH.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------
//  in      | in  | in_valid/in_ready  | in_word_t  (command, operands, widths)
//  out     | out | out_valid/out_ready| out_word_t (result, bad_command)
//
// Throughput: one word per cycle while the output is not stalled. Every
// command passes the same registers in order: stage 1 (clamp, mask),
// stage 2 (simple ops, 32x32 partial products), DATA_WIDTH divider stages
// (one quotient bit each), then stage 3 (signs, product sum, final mask).
// The whole pipe advances while the output slot is empty or being drained;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module bitvector_alu_64
	import bvalu_pkg::*;
#(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	localparam int DW = DATA_WIDTH;
	localparam int WW = $clog2(DW + 1);
	localparam int IW = $clog2(DW);
	localparam int HW = (DW + 1) / 2;

	// whole-pipe enable: advance when the output slot is empty or drained
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	function automatic logic [DW-1:0] mask_of(input logic [WW-1:0] n);
		logic [DW-1:0] mm;
		mm = '0;
		for (int k = 0; k < DW; k++) mm[k] = (k < int'(n));
		return mm;
	endfunction

	function automatic logic [WW-1:0] clamp(input logic [6:0] v);
		if (v == 7'd0) return WW'(1);
		if (int'(v) > DW) return WW'(DW);
		return WW'(v);
	endfunction

	// ---------------- stage 1: clamp widths, mask operands -----------------
	logic          v_s1;
	logic [4:0]    cmd_s1;
	logic [WW-1:0] w_s1, fw_s1, sw_s1;
	logic [DW-1:0] m_s1, a_s1, b_s1, ra_s1, rb_s1;
	logic [63:0]   bhi_s1;
	logic [5:0]    c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_data.command;
			w_s1   <= clamp(in_data.result_width);
			fw_s1  <= clamp(in_data.first_width);
			sw_s1  <= clamp(in_data.second_width);
			m_s1   <= mask_of(clamp(in_data.result_width));
			a_s1   <= in_data.operand_a[DW-1:0] & mask_of(clamp(in_data.result_width));
			b_s1   <= in_data.operand_b[DW-1:0] & mask_of(clamp(in_data.result_width));
			ra_s1  <= in_data.operand_a[DW-1:0];
			rb_s1  <= in_data.operand_b[DW-1:0];
			bhi_s1 <= in_data.operand_b;
			c_s1   <= in_data.operand_c;
		end
	end

	// ---------------- stage 2: simple ops, magnitudes, partial products ----
	logic [DW-1:0] simple_c, mag_a, mag_b;
	logic          na_c, nb_c, bzero_c, bad_c;
	logic [IW-1:0] wm1;
	logic [63:0]   hi_c;
	logic [DW-1:0] pll_c, plh_c, phl_c;

	always_comb begin
		logic [DW-1:0] fm, x;
		logic          big;
		logic [6:0]    lo;
		logic [IW-1:0] fwm1;
		wm1      = IW'(w_s1 - WW'(1));
		fwm1     = IW'(fw_s1 - WW'(1));
		na_c     = a_s1[wm1];
		nb_c     = b_s1[wm1];
		bzero_c  = (b_s1 == '0);
		mag_a    = na_c ? ((~a_s1 + DW'(1)) & m_s1) : a_s1;
		mag_b    = nb_c ? ((~b_s1 + DW'(1)) & m_s1) : b_s1;
		big      = (b_s1 >= DW'(w_s1));
		fm       = mask_of(fw_s1);
		x        = ra_s1 & fm;
		simple_c = '0;
		bad_c    = 1'b0;
		hi_c     = (bhi_s1 > 64'(DW - 1)) ? 64'(DW - 1) : bhi_s1;
		lo       = {1'b0, c_s1};
		case (cmd_s1) inside
			CMD_NOT:  simple_c = ~a_s1;
			CMD_NEG:  simple_c = ~a_s1 + DW'(1);
			CMD_SEXT: simple_c = x[fwm1] ? (x | ~fm) : x;
			CMD_ZEXT: simple_c = x;
			CMD_SHL:  simple_c = big ? '0 : (a_s1 << b_s1);
			CMD_LSHR: simple_c = big ? '0 : (a_s1 >> b_s1);
			CMD_ASHR: begin
				if (big) simple_c = na_c ? m_s1 : '0;
				else     simple_c = (a_s1 >> b_s1) | (na_c ? ~(m_s1 >> b_s1) : '0);
			end
			CMD_AND:  simple_c = a_s1 & b_s1;
			CMD_OR:   simple_c = a_s1 | b_s1;
			CMD_XOR:  simple_c = a_s1 ^ b_s1;
			CMD_SUB:  simple_c = a_s1 - b_s1;
			CMD_ADD:  simple_c = a_s1 + b_s1;
			CMD_EXTRACT: begin
				if (hi_c < 64'(lo)) simple_c = '0;
				else simple_c = (ra_s1 >> lo) &
					mask_of(WW'(hi_c[6:0] - lo + 7'd1));
			end
			CMD_CONCAT: simple_c = ((int'(sw_s1) >= 64) ? '0 : (x << sw_s1))
				| (rb_s1 & mask_of(sw_s1));
			CMD_MUL, CMD_UDIV, CMD_UREM, CMD_SDIV, CMD_SREM, CMD_SMOD: simple_c = '0;
			default:  bad_c = 1'b1;
		endcase
	end

	// partial products, zero-extended so no high bits are dropped
	always_comb begin
		pll_c = DW'(a_s1[HW-1:0]) * DW'(b_s1[HW-1:0]);
		plh_c = DW'(a_s1[HW-1:0]) * DW'(b_s1[DW-1:HW]);
		phl_c = DW'(a_s1[DW-1:HW]) * DW'(b_s1[HW-1:0]);
	end

	// packed side information carried next to the divider
	typedef struct packed {
		logic [4:0]    cmd;
		logic [DW-1:0] m;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic [DW-1:0] simple;
		logic [DW-1:0] pll, plh, phl;
		logic          na, nb, bzero, bad;
	} side_t;

	logic  v_s2;
	side_t side_s2;
	logic [DW-1:0] dn_s2, dd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.cmd    <= cmd_s1;
			side_s2.m      <= m_s1;
			side_s2.a      <= a_s1;
			side_s2.b      <= b_s1;
			side_s2.simple <= simple_c;
			side_s2.pll    <= pll_c;
			side_s2.plh    <= plh_c;
			side_s2.phl    <= phl_c;
			side_s2.na     <= na_c;
			side_s2.nb     <= nb_c;
			side_s2.bzero  <= bzero_c;
			side_s2.bad    <= bad_c;
			dn_s2 <= (cmd_s1 == CMD_UDIV || cmd_s1 == CMD_UREM) ? a_s1 : mag_a;
			dd_s2 <= (cmd_s1 == CMD_UDIV || cmd_s1 == CMD_UREM) ? b_s1 : mag_b;
		end
	end

	// ---------------- divider stages ---------------------------------------
	logic          v_dv;
	logic [DW-1:0] q_dv, r_dv;
	side_t         side_dv;

	bvalu_divider #(.W(DW), .TAG($bits(side_t))) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (dn_s2),
		.den       (dd_s2),
		.tag_in    (side_s2),
		.out_valid (v_dv),
		.quo       (q_dv),
		.rem       (r_dv),
		.tag_out   (side_dv)
	);

	// ---------------- fix-up stage: signs, product sum, select -------------
	logic [DW-1:0] fix_c;
	always_comb begin
		logic [DW-1:0] u, nu;
		u     = r_dv;
		nu    = ~r_dv + DW'(1);
		fix_c = side_dv.simple;
		case (side_dv.cmd)
			CMD_MUL:  fix_c = side_dv.pll + ((side_dv.plh + side_dv.phl) << HW);
			CMD_UDIV: fix_c = side_dv.bzero ? side_dv.m : q_dv;
			CMD_UREM: fix_c = side_dv.bzero ? side_dv.a : r_dv;
			CMD_SDIV: begin
				if (side_dv.bzero) fix_c = side_dv.na ? DW'(1) : side_dv.m;
				else fix_c = (side_dv.na != side_dv.nb) ? (~q_dv + DW'(1)) : q_dv;
			end
			CMD_SREM: fix_c = side_dv.bzero ? side_dv.a : (side_dv.na ? nu : u);
			CMD_SMOD: begin
				if (side_dv.bzero)                      fix_c = side_dv.a;
				else if (u == '0)                       fix_c = '0;
				else if (!side_dv.na && !side_dv.nb)    fix_c = u;
				else if (side_dv.na && !side_dv.nb)     fix_c = nu + side_dv.b;
				else if (!side_dv.na && side_dv.nb)     fix_c = u + side_dv.b;
				else                                    fix_c = nu;
			end
			default:  fix_c = side_dv.simple;
		endcase
	end

	logic          v_s3;
	logic [DW-1:0] r_s3;
	logic          bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3   <= fix_c & side_dv.m;
			bad_s3 <= side_dv.bad;
		end
	end

	assign out_valid            = v_s3;
	assign out_data.result      = 64'(r_s3);
	assign out_data.bad_command = bad_s3;

	// ---------------- checks -----------------------------------------------
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_command |-> out_data.result == '0)
		else $error("bad command with nonzero result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule
`default_nettype wire

// ===== hw/rtl/bvalu_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvalu_divider: pipelined unsigned divider, one quotient bit per stage
// Restoring division of two W-bit magnitudes with a side tag carried along.
// ----------------------------------------------------------------------------
module bvalu_divider #(
	parameter int W   = 64,
	parameter int TAG = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [W-1:0]   num,
	input  wire logic [W-1:0]   den,
	input  wire logic [TAG-1:0] tag_in,
	output logic                out_valid,
	output logic [W-1:0]        quo,
	output logic [W-1:0]        rem,
	output logic [TAG-1:0]      tag_out
);

	// stage i+1 registers; stage 0 is the module input
	logic [W-1:0]   n_q [1:W];
	logic [W-1:0]   d_q [1:W];
	logic [W-1:0]   r_q [1:W];
	logic [TAG-1:0] t_q [1:W];
	logic           v_q [1:W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W-1:0]   n_in, d_in, r_in;
		logic [TAG-1:0] t_in;
		logic           v_in;
		logic [W:0]     trial;
		logic [W:0]     diff;
		logic           fits;

		if (i == 0) begin : g_first
			assign n_in = num;
			assign d_in = den;
			assign r_in = '0;
			assign t_in = tag_in;
			assign v_in = in_valid;
		end else begin : g_next
			assign n_in = n_q[i];
			assign d_in = d_q[i];
			assign r_in = r_q[i];
			assign t_in = t_q[i];
			assign v_in = v_q[i];
		end

		always_comb begin
			trial = {r_in, n_in[W-1]};
			diff  = trial - {1'b0, d_in};
			fits  = !diff[W];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[i+1] <= fits ? diff[W-1:0] : trial[W-1:0];
				n_q[i+1] <= {n_in[W-2:0], fits};
				d_q[i+1] <= d_in;
				t_q[i+1] <= t_in;
			end
		end
	end

	assign out_valid = v_q[W];
	assign quo       = n_q[W];
	assign rem       = r_q[W];
	assign tag_out   = t_q[W];

endmodule
`default_nettype wire

// ===== sim/bitvector_alu_64_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitvector_alu_64_checker: result predictor and scoreboard
// Watches both channels, computes the expected result word for every
// accepted input word and compares it with the oldest pending one.
// ----------------------------------------------------------------------------
module bitvector_alu_64_checker
	import bvalu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_word_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_word_t out_data,
	output int             fail_count,
	output int             pending
);

	out_word_t result_fifo[$];

	function automatic logic [6:0] clamp_w(logic [6:0] v);
		if (v == 7'd0) return 7'd1;
		if (v > 7'd64) return 7'd64;
		return v;
	endfunction

	function automatic logic [63:0] low_ones(int n);
		if (n >= 64) return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic out_word_t evaluate(in_word_t d);
		out_word_t o;
		int w, fw, sw, lo;
		logic [63:0] m, a, b, r, x, y, hi, ma, mb, u, q;
		logic na, nb;
		w = int'(clamp_w(d.result_width));
		fw = int'(clamp_w(d.first_width));
		sw = int'(clamp_w(d.second_width));
		m = low_ones(w);
		a = d.operand_a & m;
		b = d.operand_b & m;
		na = a[6'(w - 1)];
		nb = b[6'(w - 1)];
		ma = na ? ((64'd0 - a) & m) : a;
		mb = nb ? ((64'd0 - b) & m) : b;
		r = '0;
		o.bad_command = 1'b0;
		case (d.command)
			CMD_NOT: r = ~a;
			CMD_NEG: r = 64'd0 - a;
			CMD_SEXT: begin
				x = d.operand_a & low_ones(fw);
				if (x[6'(fw - 1)]) x = x | ~low_ones(fw);
				r = x;
			end
			CMD_ZEXT: r = d.operand_a & low_ones(fw);
			CMD_SHL:  r = (b >= 64'(w)) ? '0 : (a << b);
			CMD_LSHR: r = (b >= 64'(w)) ? '0 : (a >> b);
			CMD_ASHR: begin
				if (b >= 64'(w)) r = na ? m : '0;
				else begin
					r = a >> b;
					if (na) r = r | ~(m >> b);
				end
			end
			CMD_AND: r = a & b;
			CMD_OR:  r = a | b;
			CMD_XOR: r = a ^ b;
			CMD_SUB: r = a - b;
			CMD_EXTRACT: begin
				hi = d.operand_b;
				lo = int'(d.operand_c);
				if (hi > 64'd63) hi = 64'd63;
				if (hi < 64'(lo)) r = '0;
				else r = (d.operand_a >> lo) & low_ones(int'(hi) - lo + 1);
			end
			CMD_CONCAT: begin
				x = d.operand_a & low_ones(fw);
				y = d.operand_b & low_ones(sw);
				r = ((sw >= 64) ? 64'd0 : (x << sw)) | y;
			end
			CMD_MUL: r = a * b;
			CMD_ADD: r = a + b;
			CMD_UDIV: r = (b == 0) ? m : a / b;
			CMD_UREM: r = (b == 0) ? a : a % b;
			CMD_SDIV: begin
				if (b == 0) r = na ? 64'd1 : m;
				else begin
					q = ma / mb;
					r = (na != nb) ? (64'd0 - q) : q;
				end
			end
			CMD_SREM: begin
				if (b == 0) r = a;
				else begin
					u = ma % mb;
					r = na ? (64'd0 - u) : u;
				end
			end
			CMD_SMOD: begin
				if (b == 0) r = a;
				else begin
					u = ma % mb;
					if (u == 0) r = '0;
					else if (!na && !nb) r = u;
					else if (na && !nb) r = (64'd0 - u) + b;
					else if (!na && nb) r = u + b;
					else r = 64'd0 - u;
				end
			end
			default: begin
				o.bad_command = 1'b1;
				r = '0;
			end
		endcase
		o.result = r & m;
		return o;
	endfunction

	assign pending = result_fifo.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		out_word_t want;
		int errs;
		errs = 0;
		if (arst_n && in_valid && in_ready)
			result_fifo = {result_fifo, evaluate(in_data)};
		if (arst_n && out_valid && out_ready) begin
			if (result_fifo.size() == 0) begin
				$display("%0t: unexpected word %h", $time, out_data);
				errs = errs + 1;
			end else begin
				want = result_fifo.pop_front();
				if (want.result !== out_data.result) begin
					$display("%0t: result expected %h actual %h", $time,
						want.result, out_data.result);
					errs = errs + 1;
				end
				if (want.bad_command !== out_data.bad_command) begin
					$display("%0t: bad_command expected %b actual %b", $time,
						want.bad_command, out_data.bad_command);
					errs = errs + 1;
				end
			end
		end
		if (errs != 0)
			fail_count <= fail_count + errs;
	end

endmodule

// ===== sim/bitvector_alu_64_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitvector_alu_64_tb: stimulus and verdict for the bit-vector ALU
// Directed corner words, then random words under random idling on both
// sides, a long output stall and a full drain; the checker scores results.
// ----------------------------------------------------------------------------
module bitvector_alu_64_tb;
	import bvalu_pkg::*;

	localparam int LATENCY = 66;
	localparam int N_RANDOM = 1900;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;
	int        fail_count;
	int        pending;
	bit        long_stall = 1'b0;   // request for a long receiver hold-off
	bit        stall_done = 1'b0;

	always #5 clk = ~clk;

	bitvector_alu_64 u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	bitvector_alu_64_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Random 64-bit pattern biased toward edge values.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'd1 << $urandom_range(0, 63);
			4: return 64'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Widths mostly legal, occasionally zero or above 64 (clamped).
	function automatic logic [6:0] pick_width();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'($urandom_range(65, 127));
			2: return 7'd64;
			3: return 7'd1;
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic in_word_t random_word();
		in_word_t d;
		d.command = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
			: 5'($urandom_range(0, 19));
		d.operand_a = pick_operand();
		d.operand_b = pick_operand();
		if (d.command == CMD_EXTRACT && $urandom_range(0, 2) != 0)
			d.operand_b = 64'($urandom_range(0, 70));
		if ((d.command == CMD_SHL || d.command == CMD_LSHR || d.command == CMD_ASHR)
				&& $urandom_range(0, 2) != 0)
			d.operand_b = 64'($urandom_range(0, 70));
		d.operand_c = 6'($urandom);
		d.result_width = pick_width();
		d.first_width = pick_width();
		d.second_width = pick_width();
		return d;
	endfunction

	function automatic in_word_t make_word(logic [4:0] c, logic [63:0] a,
			logic [63:0] b, logic [5:0] lo, logic [6:0] w, logic [6:0] fw,
			logic [6:0] sw);
		in_word_t d;
		d.command = c; d.operand_a = a; d.operand_b = b; d.operand_c = lo;
		d.result_width = w; d.first_width = fw; d.second_width = sw;
		return d;
	endfunction

	// Offer one word, hold it until accepted. Valid stays up across
	// back-to-back words and drops only for an idle gap.
	task automatic send_word(in_word_t d, bit idle);
		int gap;
		gap = idle ? int'($urandom_range(0, 4)) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Receiver: random ready, with one long hold-off on request.
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if (long_stall && !stall_done) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_done = 1'b1;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			if (wait_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners.
		for (k = 0; k < 20; k++)
			send_word(make_word(5'(k), '1, 64'd3, 6'd0, 7'd64, 7'd64, 7'd64), 1'b0);
		send_word(make_word(5'd31, '1, '1, 6'd63, 7'd127, 7'd0, 7'd0), 1'b0);
		send_word(make_word(CMD_SDIV, 64'h8000_0000_0000_0000, '1, 6'd0,
			7'd64, 7'd64, 7'd64), 1'b0);
		send_word(make_word(CMD_SDIV, 64'h80, 64'd0, 6'd0, 7'd8, 7'd8, 7'd8), 1'b0);
		send_word(make_word(CMD_SMOD, 64'hF9, 64'd3, 6'd0, 7'd8, 7'd8, 7'd8), 1'b0);
		send_word(make_word(CMD_ASHR, 64'h80, 64'd9, 6'd0, 7'd8, 7'd8, 7'd8), 1'b0);
		send_word(make_word(CMD_EXTRACT, '1, 64'd100, 6'd5, 7'd64, 7'd64, 7'd64), 1'b0);
		send_word(make_word(CMD_EXTRACT, '1, 64'd2, 6'd5, 7'd64, 7'd64, 7'd64), 1'b0);
		send_word(make_word(CMD_CONCAT, '1, '1, 6'd0, 7'd64, 7'd40, 7'd40), 1'b0);

		// Random part; a long output stall early, a drain midway.
		for (k = 0; k < N_RANDOM; k++) begin
			if (k == 100) long_stall = 1'b1;
			if (k == 1000) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_word(random_word(), (k % 400) >= 150);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
